>>> rtl/core/first_fit_bitmap_allocator_core_assert.svh
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define FAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// condition implies consequence in the following cycle
`define FAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

>>> rtl/core/fab_pkg.sv
// shared types and constants of the first-fit bitmap allocator
package fab_pkg;

    // map geometry
    localparam int CAPACITY_DEFAULT = 256;
    localparam int WORD_BITS        = 8;
    localparam int WORD_SH          = $clog2(WORD_BITS);

    // field widths
    localparam int START_W  = 8;
    localparam int LEN_W    = 9;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 8;
    localparam int COUNT9_W = 9;
    localparam int SUM_W    = 48;
    localparam int OPS_W    = 32;

    // packed beat widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 120;
    localparam int OUT_PAD_W  = OUT_DATA_W - GRANT_W - 3 * COUNT9_W - SUM_W - OPS_W;

    // request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SEARCH,
        ST_VERIFY,
        ST_MARK_PRIME,
        ST_MARK,
        ST_EXT_PRIME,
        ST_EXT,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/core/first_fit_bitmap_allocator_core.sv
// first-fit allocator over an occupancy bitmap held in ram, one 8-bit word examined per cycle
// after reset a clearing pass zeroes all CAPACITY/8 words (rounded up); no beat taken then
// allocate: accept, search word by word, prime, mark word by word, finish
// free: accept, verify each word, prime, clear each word, prime, extent scan word by word
// from the top down, finish; one request at a time, the ram's single read port sets the pace
// reset is asynchronous active low and clears control, counters and statistics
`include "first_fit_bitmap_allocator_core_assert.svh"

module first_fit_bitmap_allocator_core #(
    parameter int CAPACITY = fab_pkg::CAPACITY_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // block_start [7:0], block_length [16:8], zero pad above
    input  logic [fab_pkg::IN_DATA_W-1:0]   s_tdata,
    // mode [0]
    input  logic [fab_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // granted_start [7:0], extent [16:8], peak_extent [25:17], units_in_use [34:26],
    // extent_sum [82:35], operation_count [114:83], zero pad above
    output logic [fab_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [fab_pkg::STATUS_W-1:0]    m_tuser
);

    import fab_pkg::*;

    localparam int WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int XW    = WAW + WORD_SH;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
    localparam logic [XW:0]    CAP_X     = (XW + 1)'(CAPACITY);

    // registers
    state_t                state_reg, state_next;
    logic [WAW-1:0]        word_reg, word_next;
    logic [CW-1:0]         run_reg, run_next;
    logic [XW-1:0]         lo_reg, lo_next;
    logic [XW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         len_reg, len_next;
    logic                  mode_reg, mode_next;
    status_t               status_reg, status_next;
    logic [CW-1:0]         ext_new_reg, ext_new_next;
    logic [CW-1:0]         ext_reg, ext_next;
    logic [CW-1:0]         peak_reg, peak_next;
    logic [CW-1:0]         units_reg, units_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [OPS_W-1:0]      count_reg, count_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    status_t               out_status_reg, out_status_next;

    // ram ports
    logic                  wr_en;
    logic [WAW-1:0]        rd_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic [WORD_BITS-1:0]  rd_data;

    // request fields
    logic                  in_mode;
    logic [START_W-1:0]    in_start;
    logic [LEN_W-1:0]      in_len;
    logic                  accept;
    logic                  alloc_fits;
    logic                  free_fits;
    logic [XW-1:0]         start_idx;

    // word evaluation
    logic [XW-1:0]         base_idx;
    logic [XW-1:0]         bit_idx [WORD_BITS];
    logic [WORD_BITS-1:0]  bit_occ;
    logic [WORD_BITS-1:0]  range_mask;
    logic                  found_v;
    logic [XW-1:0]         hit_v;
    logic [CW-1:0]         run_v;
    logic [XW-1:0]         top_v;
    logic [CW-1:0]         ext_scan;
    logic [XW-1:0]         lo_prime;
    logic                  at_hi;
    logic                  out_free;
    logic [CW-1:0]         alloc_ext;
    logic [SUM_W:0]        sum_wide;

    fab_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (word_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // unpack the request beat
    assign in_mode    = s_tuser[0];
    assign in_start   = s_tdata[START_W-1:0];
    assign in_len     = s_tdata[START_W +: LEN_W];
    assign accept     = s_tvalid && s_tready;
    assign alloc_fits = (32'(in_len) <= 32'(CAPACITY));
    assign free_fits  = ((32'(in_start) + 32'(in_len)) <= 32'(CAPACITY));
    assign start_idx  = XW'(in_start);

    // per-bit unit index, occupancy and range mask of the word on the read port
    assign base_idx = {word_reg, {WORD_SH{1'b0}}};
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            bit_idx[b]    = base_idx + XW'(b);
            bit_occ[b]    = rd_data[b] || ({1'b0, bit_idx[b]} >= CAP_X);
            range_mask[b] = (bit_idx[b] >= lo_reg) && (bit_idx[b] <= hi_reg);
        end
    end

    // free run search through the word
    always_comb
    begin
        run_v   = run_reg;
        found_v = 1'b0;
        hit_v   = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (!found_v)
            begin
                if (bit_occ[b])
                begin
                    run_v = '0;
                end
                else
                begin
                    run_v = run_v + CW'(1);
                    if (run_v == len_reg)
                    begin
                        found_v = 1'b1;
                        hit_v   = bit_idx[b];
                    end
                end
            end
        end
    end

    // highest used unit of the word
    always_comb
    begin
        top_v = base_idx;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (rd_data[b])
            begin
                top_v = bit_idx[b];
            end
        end
    end

    assign ext_scan  = CW'(top_v) + CW'(1);
    assign lo_prime  = (mode_reg == MODE_ALLOC) ? (hi_reg - XW'(len_reg) + XW'(1)) : lo_reg;
    assign at_hi     = (word_reg == hi_reg[XW-1:WORD_SH]);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign alloc_ext = ((CW'(hi_reg) + CW'(1)) > ext_reg) ? (CW'(hi_reg) + CW'(1)) : ext_reg;
    assign sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(ext_new_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (word_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == MODE_ALLOC)
                    begin
                        state_next = (in_len == '0 || !alloc_fits) ? ST_FINISH : ST_SEARCH;
                    end
                    else
                    begin
                        state_next = (in_len == '0 || !free_fits) ? ST_FINISH : ST_VERIFY;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (found_v)
                begin
                    state_next = ST_MARK_PRIME;
                end
                else if (word_reg == LAST_WORD)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_VERIFY:
            begin
                if ((rd_data & range_mask) != range_mask)
                begin
                    state_next = ST_FINISH;
                end
                else if (at_hi)
                begin
                    state_next = ST_MARK_PRIME;
                end
            end
            ST_MARK_PRIME:
            begin
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                if (at_hi)
                begin
                    state_next = (mode_reg == MODE_ALLOC) ? ST_FINISH : ST_EXT_PRIME;
                end
            end
            ST_EXT_PRIME:
            begin
                state_next = ST_EXT;
            end
            ST_EXT:
            begin
                if (rd_data != '0 || word_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // ram control and handshake outputs
    always_comb
    begin
        s_tready = 1'b0;
        wr_en    = 1'b0;
        wr_data  = '0;
        rd_addr  = word_reg;
        case (state_reg)
            ST_INIT:
            begin
                wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                rd_addr  = (in_mode == MODE_ALLOC) ? '0 : start_idx[XW-1:WORD_SH];
            end
            ST_SEARCH, ST_VERIFY:
            begin
                rd_addr = word_reg + WAW'(1);
            end
            ST_MARK_PRIME:
            begin
                rd_addr = lo_prime[XW-1:WORD_SH];
            end
            ST_MARK:
            begin
                rd_addr = word_reg + WAW'(1);
                wr_en   = 1'b1;
                wr_data = (mode_reg == MODE_ALLOC) ? (rd_data | range_mask)
                                                   : (rd_data & ~range_mask);
            end
            ST_EXT_PRIME:
            begin
                rd_addr = LAST_WORD;
            end
            ST_EXT:
            begin
                rd_addr = word_reg - WAW'(1);
            end
            default:
            begin
                rd_addr = word_reg;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        word_next       = word_reg;
        run_next        = run_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        len_next        = len_reg;
        mode_next       = mode_reg;
        status_next     = status_reg;
        ext_new_next    = ext_new_reg;
        ext_next        = ext_reg;
        peak_next       = peak_reg;
        units_next      = units_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            ST_INIT:
            begin
                word_next = word_reg + WAW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next    = in_mode;
                    len_next     = CW'(in_len);
                    run_next     = '0;
                    word_next    = '0;
                    lo_next      = '0;
                    hi_next      = '0;
                    status_next  = STATUS_OK;
                    ext_new_next = ext_reg;
                    if (in_mode == MODE_ALLOC)
                    begin
                        if (!alloc_fits)
                        begin
                            status_next = STATUS_NO_SPACE;
                        end
                    end
                    else
                    begin
                        if (!free_fits)
                        begin
                            status_next = STATUS_BAD_FREE;
                        end
                        lo_next   = start_idx;
                        hi_next   = XW'(32'(in_start) + 32'(in_len) - 32'd1);
                        word_next = start_idx[XW-1:WORD_SH];
                    end
                end
            end
            ST_SEARCH:
            begin
                run_next = run_v;
                if (found_v)
                begin
                    hi_next = hit_v;
                end
                else if (word_reg == LAST_WORD)
                begin
                    status_next = STATUS_NO_SPACE;
                end
                else
                begin
                    word_next = word_reg + WAW'(1);
                end
            end
            ST_VERIFY:
            begin
                if ((rd_data & range_mask) != range_mask)
                begin
                    status_next = STATUS_BAD_FREE;
                end
                else if (!at_hi)
                begin
                    word_next = word_reg + WAW'(1);
                end
            end
            ST_MARK_PRIME:
            begin
                lo_next   = lo_prime;
                word_next = lo_prime[XW-1:WORD_SH];
            end
            ST_MARK:
            begin
                if (!at_hi)
                begin
                    word_next = word_reg + WAW'(1);
                end
                else if (mode_reg == MODE_ALLOC)
                begin
                    ext_new_next = alloc_ext;
                end
            end
            ST_EXT_PRIME:
            begin
                word_next = LAST_WORD;
            end
            ST_EXT:
            begin
                if (rd_data != '0)
                begin
                    ext_new_next = ext_scan;
                end
                else if (word_reg == '0)
                begin
                    ext_new_next = '0;
                end
                else
                begin
                    word_next = word_reg - WAW'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    // commit statistics on success
                    if (status_reg == STATUS_OK)
                    begin
                        ext_next   = ext_new_reg;
                        peak_next  = (ext_new_reg > peak_reg) ? ext_new_reg : peak_reg;
                        units_next = (mode_reg == MODE_ALLOC) ? (units_reg + len_reg)
                                                              : (units_reg - len_reg);
                        sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
                        count_next = (count_reg == {OPS_W{1'b1}}) ? count_reg
                                                                  : (count_reg + OPS_W'(1));
                    end
                    // load the result beat
                    m_tvalid_next   = 1'b1;
                    out_status_next = status_reg;
                    out_data_next   = {
                        {OUT_PAD_W{1'b0}},
                        count_next,
                        sum_next,
                        COUNT9_W'(units_next),
                        COUNT9_W'(peak_next),
                        COUNT9_W'(ext_next),
                        ((status_reg == STATUS_OK && mode_reg == MODE_ALLOC)
                            ? GRANT_W'(lo_reg) : {GRANT_W{1'b0}})
                    };
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            word_reg     <= '0;
            ext_reg      <= '0;
            peak_reg     <= '0;
            units_reg    <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            word_reg     <= word_next;
            ext_reg      <= ext_next;
            peak_reg     <= peak_next;
            units_reg    <= units_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // request payload and result beat registers
    always_ff @(posedge clk)
    begin
        run_reg        <= run_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        len_reg        <= len_next;
        mode_reg       <= mode_next;
        status_reg     <= status_next;
        ext_new_reg    <= ext_new_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // checks
    `FAB_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, accept, !s_tready)
    `FAB_ASSERT_NOW(a_peak_covers_extent, clk, rst_n, 1'b1, peak_reg >= ext_reg)
    `FAB_ASSERT_NOW(a_units_in_map, clk, rst_n, 1'b1, units_reg <= CW'(CAPACITY))
    `FAB_ASSERT_NOW(a_no_space_no_grant, clk, rst_n, m_tvalid && m_tuser == STATUS_NO_SPACE, m_tdata[GRANT_W-1:0] == '0)

endmodule

>>> rtl/core/fab_ram.sv
// generic single-write, single-read ram with registered read data
module fab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
